// ===== sv/eyvm_pkg.sv =====
// ----------------------------------------------------------------------------
// eyvm_pkg
// Shared constants, types and helpers of the Y-X-Z Euler view matrix block.
// ----------------------------------------------------------------------------
package eyvm_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int HALF_PI_Q13  = 12868;
    localparam int PI_Q13       = 25736;
    localparam int ONE_Q14      = 16384;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032875;

    // CORDIC datapath widths: x/y stay below 2^31 in magnitude, z below 2^19
    localparam int XY_W = 34;
    localparam int Z_W  = 20;

    typedef logic signed [XY_W-1:0] xy_t;
    typedef logic signed [Z_W-1:0]  zang_t;
    typedef logic signed [15:0]     q14_t;
    typedef logic [3:0]             step_t;

    // one sine/cosine pair in Q2.14
    typedef struct packed {
        q14_t s;
        q14_t c;
    } sc_t;

    // in-flight CORDIC lane state
    typedef struct packed {
        xy_t   x;
        xy_t   y;
        zang_t z;
        logic  flip;
    } cordic_t;

    function automatic zang_t atan_q16(input step_t i);
        zang_t r;
        case (i)
            4'd0:    r = 20'sd51472;
            4'd1:    r = 20'sd30386;
            4'd2:    r = 20'sd16055;
            4'd3:    r = 20'sd8150;
            4'd4:    r = 20'sd4091;
            4'd5:    r = 20'sd2047;
            4'd6:    r = 20'sd1024;
            4'd7:    r = 20'sd512;
            4'd8:    r = 20'sd256;
            4'd9:    r = 20'sd128;
            4'd10:   r = 20'sd64;
            4'd11:   r = 20'sd32;
            4'd12:   r = 20'sd16;
            4'd13:   r = 20'sd8;
            4'd14:   r = 20'sd4;
            default: r = 20'sd2;
        endcase
        return r;
    endfunction

    // clamp a wide signed value to [-1, 1] in Q2.14
    function automatic q14_t clamp_q14(input logic signed [47:0] v);
        q14_t r;
        if (v > 48'sd16384)
            r = 16'sd16384;
        else if (v < -48'sd16384)
            r = -16'sd16384;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// ===== sv/euler_yxz_view_matrix.sv =====
// Pipeline: 23 register stages between the input transfer and the result transfer
// (18 CORDIC stages with the final rounding, 3 axis stages, 2 translation stages).
// Throughput: one pose per cycle while the result is not stalled; set by the fully unrolled CORDIC lanes.
// The whole pipeline stalls together when the result is stalled.
// Reset: rst_n (asynchronous, active low) clears all valid bits.
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix
// View matrix of a camera from Y-X-Z Euler angles in fixed point.
// ----------------------------------------------------------------------------
module euler_yxz_view_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] pitch_angle,
    input  logic signed [15:0] yaw_angle,
    input  logic signed [15:0] roll_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] u_x,
    output logic signed [15:0] u_y,
    output logic signed [15:0] u_z,
    output logic signed [15:0] v_x,
    output logic signed [15:0] v_y,
    output logic signed [15:0] v_z,
    output logic signed [15:0] w_x,
    output logic signed [15:0] w_y,
    output logic signed [15:0] w_z,
    output logic signed [31:0] trans_u,
    output logic signed [31:0] trans_v,
    output logic signed [31:0] trans_w
);

    localparam int ROT_LAT = eyvm_pkg::CORDIC_STEPS + 2 + 3; // r valid
    localparam int LAT     = ROT_LAT + 2;                   // t valid

    logic                adv;
    logic [LAT-1:0]      vld_reg;
    logic [LAT-1:0]      vld_next;
    eyvm_pkg::sc_t       sc_yaw, sc_pitch, sc_roll;
    eyvm_pkg::q14_t      r [9];
    logic signed [31:0]  t [3];
    logic signed [31:0]  pd_reg [ROT_LAT][3];
    eyvm_pkg::q14_t      rd_reg [2][9];

    // pipeline moves whenever the output slot is free or will be taken
    assign adv      = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !adv;

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    eyvm_cordic u_cyaw (.clk(clk), .adv(adv), .angle(yaw_angle), .sc(sc_yaw));
    eyvm_cordic u_cpitch (.clk(clk), .adv(adv), .angle(pitch_angle), .sc(sc_pitch));
    eyvm_cordic u_croll (.clk(clk), .adv(adv), .angle(roll_angle), .sc(sc_roll));

    eyvm_axes u_axes (
        .clk(clk), .adv(adv), .yaw(sc_yaw), .pitch(sc_pitch), .roll(sc_roll), .r(r)
    );

    // position delay line to meet the rotation entries, and rotation entries delayed to meet the translation
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pd_reg[0][0] <= pos_x;
            pd_reg[0][1] <= pos_y;
            pd_reg[0][2] <= pos_z;
            for (int k = 1; k < ROT_LAT; k++)
                pd_reg[k] <= pd_reg[k-1];
            rd_reg[0] <= r;
            rd_reg[1] <= rd_reg[0];
        end
    end

    eyvm_trans u_trans (
        .clk(clk), .adv(adv), .r(r),
        .px(pd_reg[ROT_LAT-1][0]), .py(pd_reg[ROT_LAT-1][1]), .pz(pd_reg[ROT_LAT-1][2]),
        .t(t)
    );

    assign out_valid = vld_reg[LAT-1];
    assign u_x = rd_reg[1][0];
    assign u_y = rd_reg[1][1];
    assign u_z = rd_reg[1][2];
    assign v_x = rd_reg[1][3];
    assign v_y = rd_reg[1][4];
    assign v_z = rd_reg[1][5];
    assign w_x = rd_reg[1][6];
    assign w_y = rd_reg[1][7];
    assign w_z = rd_reg[1][8];
    assign trans_u = t[0];
    assign trans_v = t[1];
    assign trans_w = t[2];

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(trans_u) && $stable(u_x))
        else $error("result changed while stalled");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");
    a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (w_y <= 16'sd16384) && (w_y >= -16'sd16384))
        else $error("rotation entry out of range");
`endif

endmodule

// ===== sv/eyvm_cordic.sv =====
// ----------------------------------------------------------------------------
// eyvm_cordic
// Unrolled 16-stage CORDIC, one rotation step per register stage, giving
// sine and cosine of one Q3.13 angle in Q2.14. Advances when adv is high.
// ----------------------------------------------------------------------------
module eyvm_cordic (
    input  logic                   clk,
    input  logic                   adv,
    input  logic signed [15:0]     angle,
    output eyvm_pkg::sc_t          sc
);

    eyvm_pkg::cordic_t st_reg   [eyvm_pkg::CORDIC_STEPS+1];
    eyvm_pkg::cordic_t st_next  [eyvm_pkg::CORDIC_STEPS+1];
    eyvm_pkg::sc_t     sc_reg;
    eyvm_pkg::sc_t     sc_next;
    logic signed [16:0] red;
    logic               flip;
    logic signed [47:0] xr;
    logic signed [47:0] yr;

    // quadrant fold into [-pi/2, pi/2]
    always_comb
    begin
        red  = 17'(angle);
        flip = 1'b0;
        if (angle > 16'sd12868)
        begin
            red  = 17'(angle) - 17'sd25736;
            flip = 1'b1;
        end
        else if (angle < -16'sd12868)
        begin
            red  = 17'(angle) + 17'sd25736;
            flip = 1'b1;
        end
        st_next[0].x    = eyvm_pkg::CORDIC_GAIN_Q30;
        st_next[0].y    = '0;
        st_next[0].z    = eyvm_pkg::Z_W'(red) <<< 3;
        st_next[0].flip = flip;
    end

    for (genvar i = 0; i < eyvm_pkg::CORDIC_STEPS; i++)
    begin : g_step
        always_comb
        begin
            st_next[i+1].flip = st_reg[i].flip;
            if (st_reg[i].z >= 0)
            begin
                st_next[i+1].x = st_reg[i].x - (st_reg[i].y >>> i);
                st_next[i+1].y = st_reg[i].y + (st_reg[i].x >>> i);
                st_next[i+1].z = st_reg[i].z - eyvm_pkg::atan_q16(4'(i));
            end
            else
            begin
                st_next[i+1].x = st_reg[i].x + (st_reg[i].y >>> i);
                st_next[i+1].y = st_reg[i].y - (st_reg[i].x >>> i);
                st_next[i+1].z = st_reg[i].z + eyvm_pkg::atan_q16(4'(i));
            end
        end
    end

    always_comb
    begin
        xr = (48'(st_reg[eyvm_pkg::CORDIC_STEPS].x) + 48'sd32768) >>> 16;
        yr = (48'(st_reg[eyvm_pkg::CORDIC_STEPS].y) + 48'sd32768) >>> 16;
        sc_next.c = eyvm_pkg::clamp_q14(xr);
        sc_next.s = eyvm_pkg::clamp_q14(yr);
        if (st_reg[eyvm_pkg::CORDIC_STEPS].flip)
        begin
            sc_next.c = -sc_next.c;
            sc_next.s = -sc_next.s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= eyvm_pkg::CORDIC_STEPS; k++)
                st_reg[k] <= st_next[k];
            sc_reg <= sc_next;
        end
    end

    assign sc = sc_reg;

endmodule

// ===== sv/eyvm_axes.sv =====
// ----------------------------------------------------------------------------
// eyvm_axes
// Builds the nine rotation entries from the three sine/cosine pairs over
// three register stages: pair products, triple products, sum and round.
// ----------------------------------------------------------------------------
module eyvm_axes (
    input  logic              clk,
    input  logic              adv,
    input  eyvm_pkg::sc_t     yaw,
    input  eyvm_pkg::sc_t     pitch,
    input  eyvm_pkg::sc_t     roll,
    output eyvm_pkg::q14_t    r [9]
);

    typedef logic signed [31:0] p2_t;
    typedef logic signed [47:0] p3_t;

    // stage A: pair products (Q.28) plus single factors kept alongside
    p2_t c1c3_reg, s1s2_reg, c1s2_reg, c3s1_reg, c1s3_reg, s1s3_reg;
    p2_t c2s3_reg, c2c3_reg, c2s1_reg, c1c2_reg, s2_reg;
    eyvm_pkg::q14_t s3a_reg, c3a_reg;
    // stage B: Q.42 terms per entry
    p3_t t_reg [9];
    p3_t t_next [9];
    eyvm_pkg::q14_t r_reg [9];
    eyvm_pkg::q14_t r_next [9];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1c3_reg <= yaw.c * roll.c;
            s1s2_reg <= yaw.s * pitch.s;
            c1s2_reg <= yaw.c * pitch.s;
            c3s1_reg <= roll.c * yaw.s;
            c1s3_reg <= yaw.c * roll.s;
            s1s3_reg <= yaw.s * roll.s;
            c2s3_reg <= pitch.c * roll.s;
            c2c3_reg <= pitch.c * roll.c;
            c2s1_reg <= pitch.c * yaw.s;
            c1c2_reg <= yaw.c * pitch.c;
            s2_reg   <= 32'(pitch.s);
            s3a_reg  <= roll.s;
            c3a_reg  <= roll.c;
        end
    end

    // one 32x16 multiply or one shift into Q.42 per term, then sums in the next stage
    always_comb
    begin
        t_next[0] = 48'(s1s2_reg) * 48'(s3a_reg);
        t_next[1] = 48'(c2s3_reg) <<< 14;
        t_next[2] = 48'(c1s2_reg) * 48'(s3a_reg);
        t_next[3] = 48'(s1s2_reg) * 48'(c3a_reg);
        t_next[4] = 48'(c2c3_reg) <<< 14;
        t_next[5] = 48'(c1s2_reg) * 48'(c3a_reg);
        t_next[6] = 48'(c2s1_reg) <<< 14;
        t_next[7] = -(48'(s2_reg) <<< 28);
        t_next[8] = 48'(c1c2_reg) <<< 14;
    end

    p3_t c1c3_b_reg, c3s1_b_reg, c1s3_b_reg, s1s3_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
                t_reg[k] <= t_next[k];
            c1c3_b_reg <= 48'(c1c3_reg) <<< 14;
            c3s1_b_reg <= 48'(c3s1_reg) <<< 14;
            c1s3_b_reg <= 48'(c1s3_reg) <<< 14;
            s1s3_b_reg <= 48'(s1s3_reg) <<< 14;
        end
    end

    function automatic eyvm_pkg::q14_t ent(input p3_t v);
        return eyvm_pkg::clamp_q14((v + 48'sd134217728) >>> 28);
    endfunction

    always_comb
    begin
        r_next[0] = ent(c1c3_b_reg + t_reg[0]);
        r_next[1] = ent(t_reg[1]);
        r_next[2] = ent(t_reg[2] - c3s1_b_reg);
        r_next[3] = ent(t_reg[3] - c1s3_b_reg);
        r_next[4] = ent(t_reg[4]);
        r_next[5] = ent(t_reg[5] + s1s3_b_reg);
        r_next[6] = ent(t_reg[6]);
        r_next[7] = ent(t_reg[7]);
        r_next[8] = ent(t_reg[8]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
                r_reg[k] <= r_next[k];
        end
    end

    assign r = r_reg;

endmodule

// ===== sv/eyvm_trans.sv =====
// ----------------------------------------------------------------------------
// eyvm_trans
// Translation: three 16x32 products per axis, then exact sum, negate,
// round to Q16.16 and saturate. Two register stages.
// ----------------------------------------------------------------------------
module eyvm_trans (
    input  logic                clk,
    input  logic                adv,
    input  eyvm_pkg::q14_t      r [9],
    input  logic signed [31:0]  px,
    input  logic signed [31:0]  py,
    input  logic signed [31:0]  pz,
    output logic signed [31:0]  t [3]
);

    logic signed [47:0] m_reg [9];
    logic signed [31:0] t_reg [3];
    logic signed [31:0] t_next [3];
    logic signed [49:0] sum;
    logic signed [49:0] rs;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                m_reg[3*a]   <= r[3*a]   * px;
                m_reg[3*a+1] <= r[3*a+1] * py;
                m_reg[3*a+2] <= r[3*a+2] * pz;
            end
        end
    end

    always_comb
    begin
        sum = '0;
        rs  = '0;
        for (int a = 0; a < 3; a++)
        begin
            sum = -(50'(m_reg[3*a]) + 50'(m_reg[3*a+1]) + 50'(m_reg[3*a+2]));
            rs  = (sum + 50'sd8192) >>> 14;
            if (rs > 50'sd2147483647)
                t_next[a] = 32'sh7fffffff;
            else if (rs < -50'sd2147483648)
                t_next[a] = 32'sh80000000;
            else
                t_next[a] = rs[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
                t_reg[a] <= t_next[a];
        end
    end

    assign t = t_reg;

endmodule
